// File: rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// Stereo feedback delay package
// Shared types and constants: channel payloads, delay line word, sequencer
// states and the request/response format of the shared multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 17;
	localparam int CFG_IDX_W = 3;
	localparam int OPA_W    = 17;
	localparam int OPB_W    = 17;
	localparam int PROD_W   = OPA_W + OPB_W + 1;
	localparam int STEP_W   = 4;

	localparam logic [CFG_W-1:0]  WET_FULL    = 17'h10000;
	localparam logic [STEP_W-1:0] MAC_ISSUES  = 4'd8;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] dry_left;
		logic signed [SAMPLE_W-1:0] dry_right;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_left;
		logic signed [SAMPLE_W-1:0] out_right;
	} result_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} line_word_t;

	localparam int LINE_W = $bits(line_word_t);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_WHOLE    = 3'd0,
		REG_DELAY_FRACTION = 3'd1,
		REG_FEEDBACK_GAIN  = 3'd2,
		REG_LOWPASS_COEFF  = 3'd3,
		REG_WET_MIX        = 3'd4,
		REG_PING_PONG      = 3'd5,
		REG_MONO_INPUT     = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADDR,
		S_RD0,
		S_RD1,
		S_CAP,
		S_MAC,
		S_WR
	} state_t;

	typedef enum logic [2:0] {
		OP_TAP_L = 3'd0,
		OP_TAP_R = 3'd1,
		OP_LP_L  = 3'd2,
		OP_LP_R  = 3'd3,
		OP_OUT_L = 3'd4,
		OP_WR_L  = 3'd5,
		OP_WR_R  = 3'd6,
		OP_OUT_R = 3'd7
	} mac_op_t;

	typedef struct packed {
		logic                       valid;
		mac_op_t                    op;
		logic signed [OPA_W-1:0]    a;
		logic        [OPB_W-1:0]    b;
		logic signed [SAMPLE_W-1:0] base;
	} mac_req_t;

	typedef struct packed {
		logic                       valid;
		mac_op_t                    op;
		logic signed [SAMPLE_W-1:0] value;
	} mac_rsp_t;

endpackage

`default_nettype wire

// File: rtl/sfd_line_ram.sv
// ----------------------------------------------------------------------------
// Delay line memory
// Single-port RAM holding the left and right delay lines side by side;
// one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_line_ram #(
	parameter int DEPTH = 131072,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// File: rtl/sfd_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply, round and saturate unit
// Registers a signed by unsigned product, then adds the rounded Q16 result
// to a base value and saturates to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_mac (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sfd_pkg::mac_req_t req,
	output sfd_pkg::mac_rsp_t      rsp
);

	import sfd_pkg::*;

	logic                       valid_s1;
	mac_op_t                    op_s1;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [SAMPLE_W-1:0] base_s1;

	logic signed [PROD_W-1:0]   prod_rnd;
	logic signed [PROD_W-17:0]  prod_q16;
	logic signed [PROD_W-16:0]  acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			op_s1   <= req.op;
			prod_s1 <= req.a * $signed({1'b0, req.b});
			base_s1 <= req.base;
		end
	end

	always_comb begin
		prod_rnd = prod_s1 + 35'sd32768;
		prod_q16 = prod_rnd[PROD_W-1:16];
		acc      = {{4{base_s1[SAMPLE_W-1]}}, base_s1} + {prod_q16[PROD_W-17], prod_q16};
		rsp.valid = valid_s1;
		rsp.op    = op_s1;
		if (acc > 20'sd32767) begin
			rsp.value = 16'sh7FFF;
		end else if (acc < -20'sd32768) begin
			rsp.value = -16'sh8000;
		end else begin
			rsp.value = acc[SAMPLE_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: rtl/stereo_feedback_delay_unit.sv
// ----------------------------------------------------------------------------
// Stereo feedback delay unit
// Two circular delay lines with fractional read, feedback lowpass,
// optional ping-pong crossing and a dry/wet mix.
// ----------------------------------------------------------------------------
// From acceptance to the next acceptance, each stereo pair
// passes an address step, two reads of the shared single-port
// line memory (both channels sit side by side in one word), and
// eight products through a single multiplier, issued one per cycle and
// then drained, followed by the line write. The result sits in an output
// register, so a new pair is taken while the previous result waits; the write
// of the next pair holds only if that result is still untaken. The lines read
// as zero after reset without a clearing pass: entries not yet reached by the
// write pointer since reset are treated as empty until the pointer first wraps.
// Configuration is taken while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_feedback_delay_unit #(
	parameter int LINE_DEPTH = 131072
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             sample_valid,
	output logic                                  sample_stall,
	input  wire sfd_pkg::sample_t                 sample,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output sfd_pkg::result_t                      result,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [sfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [sfd_pkg::CFG_W-1:0]        cfg_data
);

	import sfd_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = ((AW > CFG_W) ? AW : CFG_W) + 1;

	state_t state_q, state_d;

	logic [16:0] delay_whole_q;
	logic [15:0] delay_fraction_q;
	logic [15:0] feedback_gain_q;
	logic [15:0] lowpass_coeff_q;
	logic [16:0] wet_mix_q;
	logic        ping_pong_q;
	logic        mono_input_q;

	logic [AW-1:0] write_index_q;
	logic          wrapped_q;
	logic signed [SAMPLE_W-1:0] lp_l_q, lp_r_q;

	logic signed [SAMPLE_W-1:0] dry_l_q, dry_r_q;
	logic [AW-1:0]  d_eff_q;
	logic [15:0]    f_q;
	logic [AW-1:0]  i0_q;
	line_word_t     s0_q, s1_q;
	logic signed [SAMPLE_W-1:0] tap_l_q, tap_r_q;
	logic signed [SAMPLE_W-1:0] wr_l_q, wr_r_q;
	logic signed [SAMPLE_W-1:0] mix_l_q, mix_r_q;
	logic [STEP_W-1:0] step_q;
	logic           rd_hit_s1;

	result_t result_q;
	logic    result_valid_q;

	logic [CW-1:0]  d_ext;
	logic [AW-1:0]  d_eff;
	logic [15:0]    f_eff;
	logic [AW:0]    diff;
	logic [AW:0]    diff_wrap;
	logic [AW-1:0]  i0;
	logic [AW-1:0]  i1;
	logic [16:0]    mix_eff;
	logic signed [SAMPLE_W-1:0] fb_l, fb_r;

	logic           mem_we;
	logic [AW-1:0]  mem_addr;
	logic [LINE_W-1:0] mem_rdata;
	line_word_t     rd_word;
	line_word_t     wr_word;
	logic           commit;

	mac_req_t mac_req;
	mac_rsp_t mac_rsp;

	sfd_line_ram #(
		.DEPTH(LINE_DEPTH),
		.WIDTH(LINE_W)
	) u_line_ram (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(wr_word),
		.rdata(mem_rdata)
	);

	sfd_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mac_req),
		.rsp   (mac_rsp)
	);

	assign rd_word      = mem_rdata;
	assign wr_word      = '{left: wr_l_q, right: wr_r_q};
	assign result       = result_q;
	assign result_valid = result_valid_q;

	// delay clamp, read addresses, wet mix clamp and feedback crossing
	always_comb begin
		d_ext = CW'(delay_whole_q);
		if (delay_whole_q == '0) begin
			d_eff = AW'(1);
			f_eff = '0;
		end else if (d_ext >= CW'(LINE_DEPTH - 1)) begin
			d_eff = AW'(LINE_DEPTH - 1);
			f_eff = '0;
		end else begin
			d_eff = AW'(d_ext);
			f_eff = delay_fraction_q;
		end

		diff      = (AW+1)'(write_index_q) - (AW+1)'(d_eff_q) - (AW+1)'(1);
		diff_wrap = diff + (AW+1)'(LINE_DEPTH);
		i0        = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];
		i1        = (i0_q == '0) ? AW'(LINE_DEPTH - 1) : i0_q - AW'(1);

		mix_eff = (wet_mix_q > WET_FULL) ? WET_FULL : wet_mix_q;
		fb_l    = ping_pong_q ? lp_r_q : lp_l_q;
		fb_r    = ping_pong_q ? lp_l_q : lp_r_q;
	end

	// shared unit operand selection
	always_comb begin
		mac_req.valid = (state_q == S_MAC) && (step_q < MAC_ISSUES);
		mac_req.op    = mac_op_t'(step_q[2:0]);
		mac_req.a     = '0;
		mac_req.b     = '0;
		mac_req.base  = '0;
		unique case (mac_req.op)
			OP_TAP_L: begin
				mac_req.a    = {s1_q.left[15], s1_q.left} - {s0_q.left[15], s0_q.left};
				mac_req.b    = {1'b0, f_q};
				mac_req.base = s0_q.left;
			end
			OP_TAP_R: begin
				mac_req.a    = {s1_q.right[15], s1_q.right} - {s0_q.right[15], s0_q.right};
				mac_req.b    = {1'b0, f_q};
				mac_req.base = s0_q.right;
			end
			OP_LP_L: begin
				mac_req.a    = {tap_l_q[15], tap_l_q} - {lp_l_q[15], lp_l_q};
				mac_req.b    = {1'b0, lowpass_coeff_q};
				mac_req.base = lp_l_q;
			end
			OP_LP_R: begin
				mac_req.a    = {tap_r_q[15], tap_r_q} - {lp_r_q[15], lp_r_q};
				mac_req.b    = {1'b0, lowpass_coeff_q};
				mac_req.base = lp_r_q;
			end
			OP_OUT_L: begin
				mac_req.a    = {tap_l_q[15], tap_l_q} - {dry_l_q[15], dry_l_q};
				mac_req.b    = mix_eff;
				mac_req.base = dry_l_q;
			end
			OP_WR_L: begin
				mac_req.a    = {fb_l[15], fb_l};
				mac_req.b    = {1'b0, feedback_gain_q};
				mac_req.base = dry_l_q;
			end
			OP_WR_R: begin
				mac_req.a    = {fb_r[15], fb_r};
				mac_req.b    = {1'b0, feedback_gain_q};
				mac_req.base = dry_r_q;
			end
			OP_OUT_R: begin
				mac_req.a    = {tap_r_q[15], tap_r_q} - {dry_r_q[15], dry_r_q};
				mac_req.b    = mix_eff;
				mac_req.base = dry_r_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sample_stall = 1'b1;
		cfg_ready    = 1'b0;
		mem_we       = 1'b0;
		mem_addr     = write_index_q;
		commit       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				sample_stall = 1'b0;
				cfg_ready    = 1'b1;
				if (sample_valid) begin
					state_d = S_ADDR;
				end
			end
			S_ADDR: begin
				state_d = S_RD0;
			end
			S_RD0: begin
				mem_addr = i0_q;
				state_d  = S_RD1;
			end
			S_RD1: begin
				mem_addr = i1;
				state_d  = S_CAP;
			end
			S_CAP: begin
				state_d = S_MAC;
			end
			S_MAC: begin
				if (step_q == MAC_ISSUES) begin
					state_d = S_WR;
				end
			end
			S_WR: begin
				if (!result_valid_q || !result_stall) begin
					mem_we  = 1'b1;
					commit  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// configuration, line state and output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_whole_q    <= 17'd1;
			delay_fraction_q <= '0;
			feedback_gain_q  <= '0;
			lowpass_coeff_q  <= 16'hFFFF;
			wet_mix_q        <= '0;
			ping_pong_q      <= 1'b0;
			mono_input_q     <= 1'b0;
			write_index_q    <= '0;
			wrapped_q        <= 1'b0;
			lp_l_q           <= '0;
			lp_r_q           <= '0;
			result_valid_q   <= 1'b0;
			step_q           <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_DELAY_WHOLE:    delay_whole_q    <= cfg_data;
					REG_DELAY_FRACTION: delay_fraction_q <= cfg_data[15:0];
					REG_FEEDBACK_GAIN:  feedback_gain_q  <= cfg_data[15:0];
					REG_LOWPASS_COEFF:  lowpass_coeff_q  <= cfg_data[15:0];
					REG_WET_MIX:        wet_mix_q        <= cfg_data;
					REG_PING_PONG:      ping_pong_q      <= cfg_data[0];
					REG_MONO_INPUT:     mono_input_q     <= cfg_data[0];
					default: ;
				endcase
			end

			if (state_q == S_CAP) begin
				step_q <= '0;
			end else if (state_q == S_MAC) begin
				step_q <= step_q + STEP_W'(1);
			end

			if (mac_rsp.valid && mac_rsp.op == OP_LP_L) begin
				lp_l_q <= mac_rsp.value;
			end
			if (mac_rsp.valid && mac_rsp.op == OP_LP_R) begin
				lp_r_q <= mac_rsp.value;
			end

			if (commit) begin
				result_valid_q <= 1'b1;
				if (write_index_q == AW'(LINE_DEPTH - 1)) begin
					write_index_q <= '0;
					wrapped_q     <= 1'b1;
				end else begin
					write_index_q <= write_index_q + AW'(1);
				end
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// per-transaction datapath
	always_ff @(posedge clk) begin
		rd_hit_s1 <= wrapped_q || (mem_addr < write_index_q);

		if (state_q == S_IDLE && sample_valid) begin
			dry_l_q <= sample.dry_left;
			dry_r_q <= mono_input_q ? sample.dry_left : sample.dry_right;
			d_eff_q <= d_eff;
			f_q     <= f_eff;
		end
		if (state_q == S_ADDR) begin
			i0_q <= i0;
		end
		if (state_q == S_RD1) begin
			s0_q <= rd_hit_s1 ? rd_word : '0;
		end
		if (state_q == S_CAP) begin
			s1_q <= rd_hit_s1 ? rd_word : '0;
		end

		if (mac_rsp.valid) begin
			case (mac_rsp.op)
				OP_TAP_L: tap_l_q <= mac_rsp.value;
				OP_TAP_R: tap_r_q <= mac_rsp.value;
				OP_OUT_L: mix_l_q <= mac_rsp.value;
				OP_OUT_R: mix_r_q <= mac_rsp.value;
				OP_WR_L:  wr_l_q  <= mac_rsp.value;
				OP_WR_R:  wr_r_q  <= mac_rsp.value;
				default: ;
			endcase
		end

		if (commit) begin
			result_q <= '{out_left: mix_l_q, out_right: mix_r_q};
		end
	end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stereo feedback delay unit testbench
// Drives stereo pairs through the unit under random idling on both sides and
// checks every result against a cycle-free model of the two delay lines, the
// feedback lowpass, the ping-pong crossing and the dry/wet mix, kept in step
// with every register write.
// ----------------------------------------------------------------------------
module tb_top;
	import sfd_pkg::*;

	localparam int DEPTH        = 131072;
	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 8;
	localparam int SETTLE_CYCLES = 24;
	localparam int MAX_REPORTS  = 10;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_stall;
	sample_t              sample       = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0]     cfg_data     = '0;

	stereo_feedback_delay_unit #(.LINE_DEPTH(DEPTH)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// model state
	logic signed [SAMPLE_W-1:0] echo_l_mem [DEPTH];
	logic signed [SAMPLE_W-1:0] echo_r_mem [DEPTH];
	int head;
	int tone_l;
	int tone_r;
	int set_delay;
	int set_frac;
	int set_gain;
	int set_tone;
	int set_wet;
	int set_cross;
	int set_mono;

	result_t expected_mix[$];
	int      mismatches;
	bit      gaps_on;
	int      hold_off_cycles;

	function automatic longint rnd16(input longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic int sat16(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return int'(v);
	endfunction

	function automatic int interp(input int s0, input int s1, input int f);
		return s0 + int'(rnd16(longint'(s1 - s0) * longint'(f)));
	endfunction

	function automatic result_t mix_next_pair(input sample_t s);
		int dl, dr, d, f, m, tl, tr, fl, fr, i0, i1;
		result_t r;
		dl = $signed(s.dry_left);
		dr = set_mono ? dl : int'($signed(s.dry_right));
		d = set_delay;
		f = set_frac;
		m = (set_wet > 65536) ? 65536 : set_wet;
		if (d < 1) begin
			d = 1;
			f = 0;
		end else if (d >= DEPTH - 1) begin
			d = DEPTH - 1;
			f = 0;
		end
		i0 = (head + 2 * DEPTH - d - 1) % DEPTH;
		i1 = (i0 + DEPTH - 1) % DEPTH;
		tl = interp(echo_l_mem[i0], echo_l_mem[i1], f);
		tr = interp(echo_r_mem[i0], echo_r_mem[i1], f);
		tone_l += int'(rnd16(longint'(tl - tone_l) * longint'(set_tone)));
		tone_r += int'(rnd16(longint'(tr - tone_r) * longint'(set_tone)));
		fl = set_cross ? tone_r : tone_l;
		fr = set_cross ? tone_l : tone_r;
		echo_l_mem[head] = SAMPLE_W'(sat16(longint'(dl) +
			rnd16(longint'(fl) * longint'(set_gain))));
		echo_r_mem[head] = SAMPLE_W'(sat16(longint'(dr) +
			rnd16(longint'(fr) * longint'(set_gain))));
		head = (head + 1) % DEPTH;
		r.out_left  = SAMPLE_W'(sat16(rnd16(longint'(dl) * longint'(65536 - m) +
			longint'(tl) * longint'(m))));
		r.out_right = SAMPLE_W'(sat16(rnd16(longint'(dr) * longint'(65536 - m) +
			longint'(tr) * longint'(m))));
		return r;
	endfunction

	task automatic clear_model();
		for (int i = 0; i < DEPTH; i++) begin
			echo_l_mem[i] = '0;
			echo_r_mem[i] = '0;
		end
		head = 0;
		tone_l = 0;
		tone_r = 0;
		set_delay = 1;
		set_frac = 0;
		set_gain = 0;
		set_tone = 65535;
		set_wet = 0;
		set_cross = 0;
		set_mono = 0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		logic [CFG_W-1:0] data;
		data = CFG_W'(value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DELAY_WHOLE:    set_delay = int'(data);
			REG_DELAY_FRACTION: set_frac  = int'(data[15:0]);
			REG_FEEDBACK_GAIN:  set_gain  = int'(data[15:0]);
			REG_LOWPASS_COEFF:  set_tone  = int'(data[15:0]);
			REG_WET_MIX:        set_wet   = int'(data);
			REG_PING_PONG:      set_cross = int'(data[0]);
			REG_MONO_INPUT:     set_mono  = int'(data[0]);
			default: ;
		endcase
	endtask

	task automatic program_all(input int d, input int f, input int g, input int c,
			input int w, input int pp, input int mono);
		write_reg(REG_DELAY_WHOLE, d);
		write_reg(REG_DELAY_FRACTION, f);
		write_reg(REG_FEEDBACK_GAIN, g);
		write_reg(REG_LOWPASS_COEFF, c);
		write_reg(REG_WET_MIX, w);
		write_reg(REG_PING_PONG, pp);
		write_reg(REG_MONO_INPUT, mono);
	endtask

	// valid stays high on return; end_burst drops it
	task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r);
		sample_t s;
		int gap;
		s.dry_left  = l;
		s.dry_right = r;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 11);
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample       <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		expected_mix.push_back(mix_next_pair(s));
	endtask

	task automatic end_burst();
		@(negedge clk);
		sample_valid <= 1'b0;
	endtask

	task automatic settle();
		while (expected_mix.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return SAMPLE_W'(int'($urandom_range(0, 63)) - 32);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic send_burst(input int count);
		repeat (count) send_pair(pick_level(), pick_level());
		end_burst();
	endtask

	task automatic pick_setting();
		case ($urandom_range(0, 9))
			0: write_reg(REG_DELAY_WHOLE, 0);
			1: write_reg(REG_DELAY_WHOLE, DEPTH - 1);
			2: write_reg(REG_DELAY_WHOLE, $urandom_range(1, DEPTH - 1));
			default: write_reg(REG_DELAY_WHOLE, $urandom_range(1, 48));
		endcase
		write_reg(REG_DELAY_FRACTION, $urandom_range(0, 'h1FFFF));
		case ($urandom_range(0, 3))
			0: write_reg(REG_FEEDBACK_GAIN, 0);
			1: write_reg(REG_FEEDBACK_GAIN, 'hFFFF);
			default: write_reg(REG_FEEDBACK_GAIN, $urandom_range(0, 'h1FFFF));
		endcase
		case ($urandom_range(0, 3))
			0: write_reg(REG_LOWPASS_COEFF, 0);
			1: write_reg(REG_LOWPASS_COEFF, 'hFFFF);
			default: write_reg(REG_LOWPASS_COEFF, $urandom_range(0, 'h1FFFF));
		endcase
		case ($urandom_range(0, 3))
			0: write_reg(REG_WET_MIX, 0);
			1: write_reg(REG_WET_MIX, int'(WET_FULL));
			2: write_reg(REG_WET_MIX, $urandom_range(0, 'h1FFFF));
			default: write_reg(REG_WET_MIX, $urandom_range(0, int'(WET_FULL)));
		endcase
		write_reg(REG_PING_PONG, $urandom_range(0, 3));
		write_reg(REG_MONO_INPUT, ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(0, 1) << 1);
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_SPARE, $urandom_range(0, 'h1FFFF));
	endtask

	task automatic test_reset_state();
		send_pair(16'sh7FFF, 16'sh8000);
		send_pair(16'sh8000, 16'sh7FFF);
		send_pair(16'sh0000, -16'sd1);
		send_pair(16'sh0001, 16'sh0000);
		end_burst();
		settle();
	endtask

	task automatic test_delay_limits();
		program_all(0, 'hFFFF, 'hFFFF, 'hFFFF, int'(WET_FULL), 0, 0);
		send_pair(16'sh7FFF, 16'sh7FFF);
		send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh7FFF, 16'sh8000);
		send_pair(16'sh8000, 16'sh7FFF);
		end_burst();
		settle();
		program_all(DEPTH - 1, 'h8000, 'h8000, 'h4000, 'h1FFFF, 0, 0);
		send_pair(16'sh1234, -16'sd4660);
		send_pair(16'sh7FFF, 16'sh8000);
		send_pair(-16'sd1, 16'sh0001);
		end_burst();
		settle();
		write_reg(REG_DELAY_WHOLE, DEPTH - 2);
		write_reg(REG_DELAY_FRACTION, 'hFFFF);
		send_pair(16'sh4000, -16'sd16384);
		send_pair(16'sh8000, 16'sh7FFF);
		end_burst();
		settle();
	endtask

	task automatic test_crossfeed_mono();
		program_all(2, 'h4000, 'hC000, 'h2000, 'h08000, 1, 1);
		send_pair(16'sh7FFF, 16'sh8000);
		send_pair(16'sh2000, 16'sh7FFF);
		send_pair(16'sh8000, 16'sh1111);
		send_pair(16'sh0000, 16'sh7FFF);
		send_pair(16'sh5555, -16'sd1);
		end_burst();
		settle();
		write_reg(REG_MONO_INPUT, 0);
		send_pair(16'sh7FFF, 16'sh8000);
		send_pair(16'sh0100, -16'sd256);
		send_pair(16'sh8000, 16'sh0000);
		end_burst();
		settle();
	endtask

	task automatic test_register_decode();
		write_reg(REG_SPARE, 'h1FFFF);
		write_reg(REG_FEEDBACK_GAIN, 'h1FFFF);
		write_reg(REG_LOWPASS_COEFF, 'h10000);
		write_reg(REG_DELAY_FRACTION, 'h1ABCD);
		write_reg(REG_PING_PONG, 'h1FFFE);
		write_reg(REG_MONO_INPUT, 'h00002);
		send_pair(16'sh7FFF, 16'sh7FFF);
		send_pair(16'sh8000, 16'sh3000);
		send_pair(16'sh0F0F, 16'sh8000);
		end_burst();
		settle();
	endtask

	task automatic test_backpressure();
		program_all(3, 'h2222, 'hA000, 'h9000, 'h0C000, 1, 0);
		hold_off_cycles = 400;
		send_burst(40);
		settle();
	endtask

	task automatic test_random_sweep();
		repeat (20) begin
			pick_setting();
			send_burst(80);
			settle();
		end
	endtask

	task automatic test_steady_stream();
		gaps_on = 1'b0;
		pick_setting();
		send_burst(200);
		settle();
	endtask

	task automatic flag_mismatch(input string what, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s: expected L=%0d R=%0d, got L=%0d R=%0d", $realtime, what,
				$signed(want.out_left), $signed(want.out_right),
				$signed(got.out_left), $signed(got.out_right));
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_mix.size() == 0)
				flag_mismatch("unexpected transaction", '0, result);
			else if (result.out_left !== expected_mix[0].out_left ||
					result.out_right !== expected_mix[0].out_right)
				flag_mismatch("result mismatch", expected_mix.pop_front(), result);
			else
				void'(expected_mix.pop_front());
		end
	end

	initial begin : result_pacer
		int burst;
		logic stall_next;
		burst = 0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				stall_next = 1'b1;
			end else if (burst > 0) begin
				burst--;
				stall_next = 1'b1;
			end else if (gaps_on && $urandom_range(0, 11) == 0) begin
				burst = $urandom_range(1, 11) - 1;
				stall_next = 1'b1;
			end else begin
				stall_next = 1'b0;
			end
			result_stall <= stall_next;
		end
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		mismatches = 0;
		gaps_on = 1'b1;
		hold_off_cycles = 0;
		clear_model();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_delay_limits();
		test_crossfeed_mono();
		test_register_decode();
		test_backpressure();
		test_random_sweep();
		test_steady_stream();

		if (mismatches == 0 && expected_mix.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
rtl/sfd_pkg.sv
rtl/sfd_line_ram.sv
rtl/sfd_mac.sv
rtl/stereo_feedback_delay_unit.sv
tb/tb_top.sv
